FILE: rtl/bldc_ol_pkg.sv
`timescale 1ns / 1ps

package bldc_ol_pkg;

  localparam int DUTY_W      = 16;
  localparam int DELAY_W     = 16;
  localparam int PHASE_W     = 3;
  localparam int STAGE_W     = 2;
  localparam int RAMP_W      = 5;
  localparam int STEP_W      = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int NUM_LVL     = 7;
  localparam int LVL_W       = 3;
  localparam int RECIP_W     = 32;

  localparam logic [RAMP_W-1:0] RAMP_MAX  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NUM  = 3'd6;

  localparam logic [DUTY_W-1:0]  FULL_DUTY_RST   = 16'd4000;
  localparam logic [DELAY_W-1:0] START_DELAY_RST = 16'd1100;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST   = 16'd180;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FULL_DUTY   = 2'd0,
    REG_REVERSE_DIR = 2'd1,
    REG_START_DELAY = 2'd2,
    REG_MIN_DELAY   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ALIGN = 3'b001,
    ST_DELAY = 3'b010,
    ST_COMM  = 3'b100
  } stage_t;

  localparam logic [STAGE_W-1:0] STAGE_CODE_ALIGN = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_CODE_DELAY = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_CODE_COMM  = 2'd2;

  typedef logic [RECIP_W-1:0] recip_t;

  // floor(2^32/d)+1 is exact for any 16-bit dividend and small d
  localparam recip_t RECIP_8  = RECIP_W'((64'd1 << 32) / 8  + 1);
  localparam recip_t RECIP_10 = RECIP_W'((64'd1 << 32) / 10 + 1);
  localparam recip_t RECIP_12 = RECIP_W'((64'd1 << 32) / 12 + 1);
  localparam recip_t RECIP_14 = RECIP_W'((64'd1 << 32) / 14 + 1);
  localparam recip_t RECIP_16 = RECIP_W'((64'd1 << 32) / 16 + 1);
  localparam recip_t RECIP_18 = RECIP_W'((64'd1 << 32) / 18 + 1);
  localparam recip_t RECIP_20 = RECIP_W'((64'd1 << 32) / 20 + 1);

  // duty level k is full_duty / (2 * ramp divider), level 0 doubles as align duty
  localparam recip_t DUTY_RECIP [NUM_LVL] = '{
    RECIP_20, RECIP_18, RECIP_16, RECIP_14, RECIP_12, RECIP_10, RECIP_8
  };

  function automatic logic [DUTY_W-1:0] div_by_recip(input logic [DUTY_W-1:0] x,
                                                      input recip_t m);
    logic [DUTY_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, x} * {{DUTY_W{1'b0}}, m};
    return prod[DUTY_W+RECIP_W-1:RECIP_W];
  endfunction

  function automatic logic [LVL_W-1:0] ramp_level(input logic [3:0] ramp);
    logic [LVL_W-1:0] lvl;
    case (ramp)
      4'd1:          lvl = 3'd0;
      4'd2:          lvl = 3'd1;
      4'd3:          lvl = 3'd2;
      4'd4, 4'd5:    lvl = 3'd3;
      4'd6, 4'd7:    lvl = 3'd4;
      4'd8, 4'd9:    lvl = 3'd5;
      default:       lvl = 3'd6;
    endcase
    return lvl;
  endfunction

  function automatic logic [STAGE_W-1:0] stage_code(input stage_t st);
    logic [STAGE_W-1:0] code;
    case (st)
      ST_ALIGN: code = STAGE_CODE_ALIGN;
      ST_DELAY: code = STAGE_CODE_DELAY;
      ST_COMM:  code = STAGE_CODE_COMM;
      default:  code = STAGE_CODE_ALIGN;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/bldc_open_loop_six_step_startup.sv
`timescale 1ns / 1ps

// an accepted item passes the input register, then the result register, before it shows on out_*
// throughput: one item per cycle unless stalled; the tick logic sits between the input register
// and the result register, and a stalled result stops the input once the input register holds an item
// reset (rst_n low, synchronous): sequencer in align, counters, duty and phase cleared,
// configuration back to full_duty 4000, clockwise, start_delay 1100, min_delay 180
module bldc_open_loop_six_step_startup (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bldc_ol_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bldc_ol_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bldc_ol_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] run, rest zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bldc_ol_pkg::OUT_TDATA_W-1:0] out_tdata   // [15:0] duty, [18:16] phase_code,
                                                          // [19] drive_change, [21:20] stage
);
  import bldc_ol_pkg::*;

  // configuration
  logic [DUTY_W-1:0]  full_duty_r;
  logic               reverse_dir_r;
  logic [DELAY_W-1:0] start_delay_r;
  logic [DELAY_W-1:0] min_delay_r;

  // duty levels derived from full_duty, refreshed every cycle
  logic [DUTY_W-1:0] duty_lvl_r [NUM_LVL];

  // input register
  logic in_valid_r;
  logic in_run_r;

  // sequencer state
  stage_t             stage_r, stage_nxt;
  logic [DELAY_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [DELAY_W-1:0] interval_r, interval_nxt;
  logic [RAMP_W-1:0]  ramp_cnt_r, ramp_cnt_nxt;
  logic [STEP_W-1:0]  step_idx_r, step_idx_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               change_nxt;

  // result register
  logic               out_valid_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic [PHASE_W-1:0] out_phase_r;
  logic               out_change_r;
  logic [STAGE_W-1:0] out_stage_r;

  logic               adv;
  logic               proc;
  logic [DELAY_W-1:0] tick_inc;
  logic [DELAY_W-1:0] shrink_q;
  logic [DELAY_W:0]   dec;
  logic [DELAY_W-1:0] shrunk;
  logic [RAMP_W-1:0]  ramp_inc;
  logic [STEP_W-1:0]  step_inc;

  assign adv       = !out_valid_r || out_tready;
  assign proc      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_duty_r   <= FULL_DUTY_RST;
      reverse_dir_r <= 1'b0;
      start_delay_r <= START_DELAY_RST;
      min_delay_r   <= MIN_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FULL_DUTY:   full_duty_r   <= cfg_wdata;
        REG_REVERSE_DIR: reverse_dir_r <= cfg_wdata[0];
        REG_START_DELAY: start_delay_r <= cfg_wdata;
        REG_MIN_DELAY:   min_delay_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_LVL; k++) begin
      duty_lvl_r[k] <= div_by_recip(full_duty_r, DUTY_RECIP[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_run_r <= in_tdata[0];
    end
  end

  // per-tick sequencer
  always_comb begin
    tick_inc = tick_cnt_r + 1'b1;
    shrink_q = div_by_recip(interval_r, RECIP_12);
    dec      = {1'b0, shrink_q} + 1'b1;
    shrunk   = (dec > {1'b0, interval_r}) ? '0 : DELAY_W'({1'b0, interval_r} - dec);
    ramp_inc = (ramp_cnt_r < RAMP_MAX) ? ramp_cnt_r + 1'b1 : ramp_cnt_r;
    step_inc = (step_idx_r == STEP_LAST) ? '0 : step_idx_r + 1'b1;

    stage_nxt    = stage_r;
    tick_cnt_nxt = tick_cnt_r;
    interval_nxt = interval_r;
    ramp_cnt_nxt = ramp_cnt_r;
    step_idx_nxt = step_idx_r;
    duty_nxt     = duty_r;
    phase_nxt    = phase_r;
    change_nxt   = 1'b0;

    if (!in_run_r) begin
      stage_nxt    = ST_ALIGN;
      tick_cnt_nxt = '0;
      ramp_cnt_nxt = '0;
      step_idx_nxt = '0;
    end else begin
      case (stage_r)
        ST_ALIGN: begin
          duty_nxt     = duty_lvl_r[0];
          phase_nxt    = '0;
          change_nxt   = 1'b1;
          tick_cnt_nxt = '0;
          interval_nxt = start_delay_r;
          stage_nxt    = ST_DELAY;
          ramp_cnt_nxt = '0;
        end
        ST_DELAY: begin
          if (tick_inc >= interval_r) begin
            tick_cnt_nxt = '0;
            stage_nxt    = ST_COMM;
          end else begin
            tick_cnt_nxt = tick_inc;
          end
        end
        ST_COMM: begin
          interval_nxt = (shrunk < min_delay_r) ? min_delay_r : shrunk;
          ramp_cnt_nxt = ramp_inc;
          // at saturation the duty stays where it is
          if (ramp_inc != '0 && ramp_inc < RAMP_MAX) begin
            duty_nxt = duty_lvl_r[ramp_level(ramp_inc[3:0])];
          end
          stage_nxt    = ST_DELAY;
          step_idx_nxt = step_inc;
          // clockwise walks the table backwards
          if (reverse_dir_r) begin
            phase_nxt = step_inc;
          end else begin
            phase_nxt = (step_inc == '0) ? '0 : STEP_NUM - step_inc;
          end
          change_nxt   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= ST_ALIGN;
      tick_cnt_r <= '0;
      interval_r <= '0;
      ramp_cnt_r <= '0;
      step_idx_r <= '0;
      duty_r     <= '0;
      phase_r    <= '0;
    end else if (proc) begin
      stage_r    <= stage_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      interval_r <= interval_nxt;
      ramp_cnt_r <= ramp_cnt_nxt;
      step_idx_r <= step_idx_nxt;
      duty_r     <= duty_nxt;
      phase_r    <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_duty_r   <= duty_nxt;
      out_phase_r  <= phase_nxt;
      out_change_r <= change_nxt;
      out_stage_r  <= stage_code(stage_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_stage_r, out_change_r, out_phase_r, out_duty_r};

  // a stopped or idle sequencer never reports a new drive pattern
  a_align_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stage_r == STAGE_CODE_ALIGN) |-> !out_change_r)
    else $error("drive change reported in align stage");

  // every applied pattern leaves the sequencer counting the next delay
  a_change_to_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_change_r |-> (out_stage_r == STAGE_CODE_DELAY))
    else $error("drive change not followed by delay stage");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_phase_r <= STEP_LAST) && (step_idx_r <= STEP_LAST))
    else $error("phase or step index out of range");

  a_ramp_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_cnt_r <= RAMP_MAX)
    else $error("ramp count beyond saturation");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !in_run_r |=> (stage_r == ST_ALIGN) && (ramp_cnt_r == '0) && (step_idx_r == '0))
    else $error("stop did not clear the sequencer");

endmodule
